// File: src/vgp_pkg.sv
// Package for the variable gap penalty unit: feature entry layout, function
// and register codes, and the fixed-point constants of the penalty arithmetic.
// No dependencies.
`default_nettype none

package vgp_pkg;

  localparam int unsigned POSITIONS_DEF = 1024;

  // Field widths of the stream items.
  localparam int unsigned POS_W     = 11;
  localparam int unsigned ACCESS_W  = 17;
  localparam int unsigned ANGLE_W   = 14;
  localparam int unsigned DIST_W    = 16;
  localparam int unsigned PEN_W     = 48;
  localparam int unsigned IN_DATA_W = 64;

  // Configuration port.
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] REG_OPEN_BASE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_EXT_BASE    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_EXT_MODE    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_W_HELIX     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_W_STRAND    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_W_BURIAL    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_W_CURVATURE = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_W_DISTANCE  = 3'd7;

  localparam logic [31:0] OPEN_BASE_RST = 32'd917504;
  localparam logic [31:0] EXT_BASE_RST  = 32'd65536;
  localparam logic [15:0] WEIGHT_RST    = 16'sd256;

  typedef enum logic [1:0] {
    FUNC_LOAD = 2'd0,
    FUNC_OPEN = 2'd1,
    FUNC_EXT  = 2'd2
  } func_e;

  typedef enum logic [1:0] {
    MODE_CONST  = 2'd0,
    MODE_LINEAR = 2'd1,
    MODE_POWER  = 2'd2
  } ext_mode_e;

  // One residue entry of the feature table, 49 bits.
  typedef struct packed {
    logic [DIST_W-1:0]          nbr_dist;
    logic signed [ANGLE_W-1:0]  angle;
    logic [ACCESS_W-1:0]        access;
    logic                       strand;
    logic                       helix;
  } feat_t;

  // Fixed-point constants.
  localparam logic [ACCESS_W-1:0] ONE_Q16     = 17'd65536;
  localparam logic [11:0]         ANGLE_180   = 12'd2880;   // 180 degrees in Q9.4
  localparam logic [10:0]         ANGLE_HALF  = 11'd1440;
  localparam logic [DIST_W-1:0]   DIST_3      = 16'd768;    // 3.0 angstrom in Q8.8
  localparam logic [PEN_W-1:0]    PEN_MAX     = 48'h7FFF_FFFF_FFFF;
  localparam logic [15:0]         COUNT_MAX   = 16'hFFFF;
  localparam logic [3:0]          LIN_TOP     = 4'd11;
  localparam logic [15:0]         LIN_STEPS   = 16'd10;
  localparam logic [3:0]          LIN_HALF    = 4'd5;
  localparam logic [31:0]         LIN_DIV     = 32'd10;

  // Radix-4 divider: 48 quotient bits, two per step.
  localparam int unsigned DIV_Q_W   = 48;
  localparam int unsigned DIV_STEPS = DIV_Q_W / 2;

endpackage

`default_nettype wire

// File: src/variable_gap_penalty_unit.sv
// Variable gap penalty unit, one item in work at a time. Depends on vgp_pkg.
// Loads, invalid positions and unused codes go straight to the result; an open
// (unless a run flag is set) and an extension (unless saturated at once) use the
// 24-step radix-4 divider, and in linear decay mode up to a count of ten a further
// division follows. A new item is taken once the result has been presented.
// Reset is synchronous and clears control state and the registers to their
// defaults; the feature table is not cleared and holds nothing until loaded.
`default_nettype none

module variable_gap_penalty_unit
  import vgp_pkg::*;
#(
  parameter int unsigned POSITIONS = POSITIONS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  // tdata: position[10:0], helix_run[11], strand_run[12], solvent_access[29:13],
  //        bend_angle[43:30], neighbor_distance[59:44], zero[63:60]
  input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,
  // tuser: func[1:0]
  input  wire logic [1:0]            s_axis_tuser,
  input  wire logic                  s_axis_tvalid,
  output logic                       s_axis_tready,
  // tdata: penalty[47:0]
  output logic [PEN_W-1:0]           m_axis_tdata,
  // tuser: status[0]
  output logic                       m_axis_tuser,
  output logic                       m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int unsigned AW    = (POSITIONS > 1) ? $clog2(POSITIONS) : 1;
  localparam int unsigned CNT_W = $clog2(DIV_STEPS);

  typedef enum logic [3:0] {
    S_IDLE,
    S_OPEN_BASE,
    S_OPEN_BURIAL,
    S_OPEN_DIST,
    S_OPEN_CURV,
    S_ROUND,
    S_EXT_DIV,
    S_EXT_LIN,
    S_LIN_DIV,
    S_DONE
  } state_t;

  state_t state;

  // Configuration registers.
  logic [31:0]        open_base;
  logic [31:0]        ext_base;
  logic [1:0]         ext_mode;
  logic signed [15:0] w_helix, w_strand, w_burial, w_curv, w_dist;

  // Unit state and working registers.
  logic [15:0]        ext_count;
  logic [PEN_W-1:0]   run_power;
  logic               ext_sat;
  logic signed [49:0] acc;
  logic [31:0]        dist_sq;
  logic [PEN_W-1:0]   res_pen;
  logic               res_stat;

  // Input item fields.
  func_e                     in_func;
  logic [POS_W-1:0]          in_pos;
  logic [ACCESS_W-1:0]       in_access;
  logic [16:0]               pos_m1;
  logic                      pos_ok;
  logic                      in_xfer;
  feat_t                     in_feat;

  // Feature table, one synchronous port.
  feat_t          feat_mem [POSITIONS];
  feat_t          mem_rdata;
  logic           mem_we;
  logic           mem_re;
  logic [AW-1:0]  mem_addr;

  // Shared divider.
  logic                   div_go;
  logic [63:0]            div_a;
  logic [31:0]            div_b;
  logic                   div_busy;
  logic [CNT_W-1:0]       div_cnt;
  logic [31:0]            div_rem;
  logic [DIV_Q_W-1:0]     div_num;
  logic [DIV_Q_W-1:0]     div_quo;
  logic [31:0]            div_d;
  logic [33:0]            div_d3;
  logic [33:0]            div_r4;
  logic [1:0]             div_digit;
  logic [33:0]            div_sub;

  // Shared multiplier for the weighted open terms.
  logic signed [15:0] mul_a;
  logic signed [33:0] mul_b;
  logic signed [49:0] mul_p;

  // Open term helpers.
  logic                flag_any;
  logic [11:0]         angle_clamp;
  logic [11:0]         angle_rest;
  logic [27:0]         curv_num;
  logic [16:0]         curv;
  logic [15:0]         dist_excess;
  logic [ACCESS_W-1:0] burial;
  logic                ext_sat_now;
  logic [35:0]         lin_num;
  logic [PEN_W-1:0]    run_power_next;
  logic [15:0]         ext_count_next;

  assign cfg_ready     = 1'b1;
  assign s_axis_tready = (state == S_IDLE);
  assign in_xfer       = s_axis_tvalid && s_axis_tready;

  assign in_func   = func_e'(s_axis_tuser);
  assign in_pos    = s_axis_tdata[10:0];
  assign in_access = s_axis_tdata[29:13];
  assign pos_m1    = 17'(in_pos) - 17'd1;
  assign pos_ok    = (in_pos != '0) && (17'(in_pos) <= 17'(POSITIONS));

  always_comb begin
    in_feat.helix    = s_axis_tdata[11];
    in_feat.strand   = s_axis_tdata[12];
    in_feat.access   = (in_access > ONE_Q16) ? ONE_Q16 : in_access;
    in_feat.angle    = s_axis_tdata[43:30];
    in_feat.nbr_dist = s_axis_tdata[59:44];
  end

  assign mem_addr = pos_m1[AW-1:0];
  assign mem_we   = in_xfer && (in_func == FUNC_LOAD) && pos_ok;
  assign mem_re   = in_xfer && (in_func == FUNC_OPEN) && pos_ok;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      feat_mem[mem_addr] <= in_feat;
    end
    if (mem_re) begin
      mem_rdata <= feat_mem[mem_addr];
    end
  end

  // Terms of the open penalty, taken from the entry read for this item.
  assign flag_any = mem_rdata.helix || mem_rdata.strand;

  always_comb begin
    if (mem_rdata.angle[ANGLE_W-1]) begin
      angle_clamp = '0;
    end else if (mem_rdata.angle > $signed({2'b00, ANGLE_180})) begin
      angle_clamp = ANGLE_180;
    end else begin
      angle_clamp = mem_rdata.angle[11:0];
    end
  end

  assign angle_rest  = ANGLE_180 - angle_clamp;
  assign curv_num    = {angle_rest, 16'b0} + 28'(ANGLE_HALF);
  assign curv        = flag_any ? ONE_Q16 : div_quo[16:0];
  assign dist_excess = (mem_rdata.nbr_dist > DIST_3) ? (mem_rdata.nbr_dist - DIST_3) : '0;
  assign burial      = ONE_Q16 - mem_rdata.access;

  // Saturation is known before dividing when the quotient reaches 2^47.
  assign ext_sat_now = (ext_base == '0) || ({15'b0, run_power[47:31]} >= ext_base);
  assign lin_num     = 36'(ext_base) * 36'(LIN_TOP - ext_count[3:0]) + 36'(LIN_HALF);
  assign run_power_next = ext_sat ? PEN_MAX : div_quo;
  assign ext_count_next = (ext_count != COUNT_MAX) ? (ext_count + 16'd1) : ext_count;

  always_comb begin
    div_go = 1'b0;
    div_a  = '0;
    div_b  = '0;
    unique case (state)
      S_IDLE: begin
        div_go = in_xfer && (in_func == FUNC_EXT) && !ext_sat_now;
        div_a  = {run_power, 16'b0};
        div_b  = ext_base;
      end
      S_OPEN_BASE: begin
        div_go = !flag_any;
        div_a  = 64'(curv_num);
        div_b  = 32'(ANGLE_180);
      end
      S_EXT_LIN: begin
        div_go = 1'b1;
        div_a  = 64'(lin_num);
        div_b  = LIN_DIV;
      end
      default: begin
        div_go = 1'b0;
      end
    endcase
  end

  always_comb begin
    mul_a = w_burial;
    mul_b = 34'(burial);
    case (state)
      S_OPEN_DIST: begin
        mul_a = w_dist;
        mul_b = 34'(dist_sq);
      end
      S_OPEN_CURV: begin
        mul_a = w_curv;
        mul_b = 34'(curv);
      end
      default: begin
        mul_a = w_burial;
        mul_b = 34'(burial);
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // Radix-4 restoring divider; the remainder always stays below the divisor.
  assign div_r4 = {div_rem, div_num[DIV_Q_W-1 -: 2]};

  always_comb begin
    if (div_r4 >= div_d3) begin
      div_digit = 2'd3;
      div_sub   = div_d3;
    end else if (div_r4 >= {1'b0, div_d, 1'b0}) begin
      div_digit = 2'd2;
      div_sub   = {1'b0, div_d, 1'b0};
    end else if (div_r4 >= {2'b00, div_d}) begin
      div_digit = 2'd1;
      div_sub   = {2'b00, div_d};
    end else begin
      div_digit = 2'd0;
      div_sub   = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      div_busy <= 1'b0;
      div_cnt  <= '0;
    end else if (div_go) begin
      div_busy <= 1'b1;
      div_cnt  <= '0;
      div_rem  <= {16'b0, div_a[63:48]};
      div_num  <= div_a[47:0];
      div_d    <= div_b;
      div_d3   <= 34'(div_b) + {1'b0, div_b, 1'b0};
    end else if (div_busy) begin
      div_rem <= 32'(div_r4 - div_sub);
      div_num <= {div_num[DIV_Q_W-3:0], 2'b00};
      div_quo <= {div_quo[DIV_Q_W-3:0], div_digit};
      div_cnt <= div_cnt + 1'b1;
      if (div_cnt == CNT_W'(DIV_STEPS - 1)) begin
        div_busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      open_base <= OPEN_BASE_RST;
      ext_base  <= EXT_BASE_RST;
      ext_mode  <= MODE_CONST;
      w_helix   <= WEIGHT_RST;
      w_strand  <= WEIGHT_RST;
      w_burial  <= WEIGHT_RST;
      w_curv    <= WEIGHT_RST;
      w_dist    <= WEIGHT_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_OPEN_BASE:   open_base <= cfg_data;
        REG_EXT_BASE:    ext_base  <= cfg_data;
        REG_EXT_MODE:    ext_mode  <= cfg_data[1:0];
        REG_W_HELIX:     w_helix   <= cfg_data[15:0];
        REG_W_STRAND:    w_strand  <= cfg_data[15:0];
        REG_W_BURIAL:    w_burial  <= cfg_data[15:0];
        REG_W_CURVATURE: w_curv    <= cfg_data[15:0];
        REG_W_DISTANCE:  w_dist    <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      ext_count     <= '0;
      run_power     <= PEN_W'(EXT_BASE_RST);
      ext_sat       <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      if (cfg_valid && cfg_ready && (cfg_index == REG_EXT_BASE)) begin
        run_power <= PEN_W'(cfg_data);
      end
      unique case (state)
        S_IDLE: begin
          if (in_xfer) begin
            res_pen  <= '0;
            res_stat <= 1'b0;
            state    <= S_DONE;
            case (in_func)
              FUNC_LOAD: begin
                res_stat <= !pos_ok;
              end
              FUNC_OPEN: begin
                res_stat <= !pos_ok;
                if (pos_ok) begin
                  ext_count <= '0;
                  run_power <= PEN_W'(ext_base);
                  state     <= S_OPEN_BASE;
                end
              end
              FUNC_EXT: begin
                ext_count <= ext_count_next;
                ext_sat   <= ext_sat_now;
                state     <= S_EXT_DIV;
              end
              default: ;
            endcase
          end
        end
        S_OPEN_BASE: begin
          acc <= $signed({10'b0, open_base, 8'b0})
               + (mem_rdata.helix  ? $signed({{18{w_helix[15]}}, w_helix, 16'b0})  : 50'sd0)
               + (mem_rdata.strand ? $signed({{18{w_strand[15]}}, w_strand, 16'b0}) : 50'sd0);
          dist_sq <= dist_excess * dist_excess;
          state   <= S_OPEN_BURIAL;
        end
        S_OPEN_BURIAL: begin
          acc   <= acc + mul_p;
          state <= S_OPEN_DIST;
        end
        S_OPEN_DIST: begin
          acc   <= acc + mul_p;
          state <= S_OPEN_CURV;
        end
        S_OPEN_CURV: begin
          if (!div_busy) begin
            acc   <= acc + mul_p;
            state <= S_ROUND;
          end
        end
        S_ROUND: begin
          // The sum is in Q.24; round half up to Q.16.
          res_pen <= 48'((acc + 50'sd128) >>> 8);
          state   <= S_DONE;
        end
        S_EXT_DIV: begin
          if (!div_busy) begin
            run_power <= run_power_next;
            state     <= S_DONE;
            case (ext_mode)
              MODE_LINEAR: begin
                if (ext_count <= LIN_STEPS) begin
                  state <= S_EXT_LIN;
                end
              end
              MODE_POWER: res_pen <= run_power_next;
              default:    res_pen <= PEN_W'(ext_base);
            endcase
          end
        end
        S_EXT_LIN: begin
          state <= S_LIN_DIV;
        end
        S_LIN_DIV: begin
          if (!div_busy) begin
            res_pen <= div_quo;
            state   <= S_DONE;
          end
        end
        S_DONE: begin
          if (!m_axis_tvalid || m_axis_tready) begin
            m_axis_tvalid <= 1'b1;
            m_axis_tdata  <= res_pen;
            m_axis_tuser  <= res_stat;
            state         <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // The divider is only started when it is free.
  a_div_free: assert property (@(posedge clk) disable iff (rst) div_go |-> !div_busy)
    else $error("divider started while busy");

  // A result is never presented while a division is still running.
  a_done_idle_div: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE) |-> !div_busy)
    else $error("result ready with divider busy");

  // A valid open restarts the extension sequence.
  a_open_restart: assert property (@(posedge clk) disable iff (rst)
    (in_xfer && (in_func == FUNC_OPEN) && pos_ok)
      |=> (ext_count == '0) && (run_power == PEN_W'($past(ext_base))))
    else $error("open did not restart extension state");

  // An extension below the limit advances the count by one.
  a_ext_count: assert property (@(posedge clk) disable iff (rst)
    (in_xfer && (in_func == FUNC_EXT) && (ext_count != COUNT_MAX))
      |=> ext_count == $past(ext_count) + 16'd1)
    else $error("extension count did not advance");

endmodule

`default_nettype wire
